### rtl/smx_pkg.sv
// Shared types and constants for the stack machine executor.
package smx_pkg;

	localparam int WORD_W  = 32;
	localparam int DATA_W  = 30;
	localparam int DEPTH_W = 9;
	localparam int STAT_W  = 3;
	localparam int DIV_CNT_W = $clog2(WORD_W + 1);

	localparam logic [1:0] KIND_PUSH     = 2'd0;
	localparam logic [1:0] KIND_PUSH_NEG = 2'd2;

	localparam logic [DATA_W-1:0] PRIM_HALT = DATA_W'(0);
	localparam logic [DATA_W-1:0] PRIM_ADD  = DATA_W'(1);
	localparam logic [DATA_W-1:0] PRIM_SUB  = DATA_W'(2);
	localparam logic [DATA_W-1:0] PRIM_MUL  = DATA_W'(3);
	localparam logic [DATA_W-1:0] PRIM_DIV  = DATA_W'(4);

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_HALT    = 3'd1,
		STAT_UNDER   = 3'd2,
		STAT_OVER    = 3'd3,
		STAT_DIVZ    = 3'd4,
		STAT_IGNORED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_TAKE_PREV,
		CELL_TAKE_NEXT
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} exec_state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctl_t;

endpackage

### rtl/stack_machine_executor_core.sv
// Top level of the stack machine executor: decode, cell chain, divider and result register.
// Each item other than a divide is executed as it is taken and its result goes to an output register,
// so a new item is taken every cycle while results are drained. The stack is a chain of
// STACK_DEPTH cells with the top in the first cell: a push shifts every entry one cell down,
// and an arithmetic primitive writes its result into the top cell and shifts the rest up.
// A divide runs through the iterative divider at one quotient bit per cycle and occupies
// the block through issue, one step per quotient bit and commit, before the next item is taken.
// Entries are not cleared at reset; only entries below the depth are ever visible.
module stack_machine_executor_core
	import smx_pkg::*;
#(
	parameter int STACK_DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [WORD_W-1:0]        instr,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] top_value,
	output logic [DEPTH_W-1:0]       depth,
	output logic [STAT_W-1:0]        status
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	exec_state_t          state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic                 halted_q, halted_d;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    top_q, top_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	status_t              status_q, status_d;
	logic                 out_load;
	logic                 accept;
	logic                 out_free;

	cell_cmd_t            cmd_top, cmd_rest;
	logic [WORD_W-1:0]    load_val;
	logic [WORD_W-1:0]    cell_data [STACK_DEPTH];

	div_ctl_t             div_ctl;
	logic                 div_done;
	logic [WORD_W-1:0]    div_quo;

	logic [1:0]           kind;
	logic [DATA_W-1:0]    code;
	logic [WORD_W-1:0]    push_val;
	logic [WORD_W-1:0]    op_a, op_b;
	logic [WORD_W-1:0]    prod;
	logic [WORD_W-1:0]    cur_top;

	assign kind     = instr[WORD_W-1:WORD_W-2];
	assign code     = instr[DATA_W-1:0];
	assign push_val = (kind == KIND_PUSH_NEG) ? (WORD_W'(0) - {2'b00, code})
	                                          : {2'b00, code};
	assign op_b     = cell_data[0];
	assign op_a     = cell_data[1];
	assign prod     = op_a * op_b;
	assign cur_top  = (count_q != '0) ? cell_data[0] : '0;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		halted_d     = halted_q;
		out_load     = 1'b0;
		top_d        = cur_top;
		depth_d      = DEPTH_W'(count_q);
		status_d     = STAT_OK;
		cmd_top      = CELL_HOLD;
		cmd_rest     = CELL_HOLD;
		load_val     = push_val;
		div_ctl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					if (halted_q) begin
						status_d = STAT_IGNORED;
					end else if (kind == KIND_PUSH || kind == KIND_PUSH_NEG) begin
						if (count_q == CNT_W'(STACK_DEPTH)) begin
							status_d = STAT_OVER;
						end else begin
							cmd_top  = CELL_TAKE_PREV;
							cmd_rest = CELL_TAKE_PREV;
							count_d  = count_q + 1'b1;
							top_d    = push_val;
							depth_d  = DEPTH_W'(count_d);
						end
					end else if (code == PRIM_HALT) begin
						halted_d = 1'b1;
						status_d = STAT_HALT;
					end else if (code > PRIM_DIV) begin
						status_d = STAT_OK;
					end else if (count_q < CNT_W'(2)) begin
						status_d = STAT_UNDER;
					end else if (code == PRIM_DIV) begin
						if (op_b == '0) begin
							status_d = STAT_DIVZ;
						end else begin
							out_load      = 1'b0;
							div_ctl.start = 1'b1;
							state_d       = ST_DIV;
						end
					end else begin
						unique case (code)
							PRIM_ADD: load_val = op_a + op_b;
							PRIM_SUB: load_val = op_a - op_b;
							default:  load_val = prod;
						endcase
						cmd_top  = CELL_TAKE_PREV;
						cmd_rest = CELL_TAKE_NEXT;
						count_d  = count_q - 1'b1;
						top_d    = load_val;
						depth_d  = DEPTH_W'(count_d);
					end
				end
			end
			ST_DIV: begin
				load_val = div_quo;
				if (div_done && out_free) begin
					div_ctl.ack = 1'b1;
					out_load    = 1'b1;
					cmd_top     = CELL_TAKE_PREV;
					cmd_rest    = CELL_TAKE_NEXT;
					count_d     = count_q - 1'b1;
					top_d       = div_quo;
					depth_d     = DEPTH_W'(count_d);
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			halted_q <= halted_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			top_q    <= top_d;
			depth_q  <= depth_d;
			status_q <= status_d;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] prev_data;
		logic [WORD_W-1:0] next_data;
		cell_cmd_t         cmd;

		if (i == 0) begin : g_first
			assign prev_data = load_val;
			assign cmd       = cmd_top;
		end else begin : g_inner
			assign prev_data = cell_data[i-1];
			assign cmd       = cmd_rest;
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		smx_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.prev_data (prev_data),
			.next_data (next_data),
			.data      (cell_data[i])
		);
	end

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (op_a),
		.divisor  (op_b),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign top_value = top_q;
	assign depth     = depth_q;
	assign status    = status_q;

	// The stack never holds more entries than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond capacity");

	// No item is taken while a divide is in flight.
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !in_ready)
		else $error("item taken during divide");

	// Once halted, the block stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	// After halting, the stack depth no longer changes.
	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && state_q == ST_IDLE |=> $stable(count_q))
		else $error("stack changed after halt");

endmodule

### rtl/smx_cell.sv
// One stack entry that loads from its upper or lower neighbor or holds.
module smx_cell
	import smx_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [WORD_W-1:0] prev_data,
	input  logic [WORD_W-1:0] next_data,
	output logic [WORD_W-1:0] data
);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_TAKE_PREV: data_q <= prev_data;
			CELL_TAKE_NEXT: data_q <= next_data;
			default:        data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

### rtl/smx_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smx_div
	import smx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    quo_q;
	logic [WORD_W-1:0]    dvs_q;
	logic                 neg_q;
	logic [WORD_W:0]      shifted;
	logic [WORD_W+1:0]    diff;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(WORD_W);
		end else if (ctl.ack) begin
			busy_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
			dvs_q <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
			neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
		end else if (busy_q && cnt_q != '0) begin
			if (!diff[WORD_W+1]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

endmodule
